// ===== hdl/pim_pkg.sv =====
// ----------------------------------------------------------------------------
// pim_pkg: shared types and constants of the priority inheritance mutex
// Holds field widths, action and status codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pim_pkg;

	localparam int WAIT_DEPTH  = 16;
	localparam int TASK_COUNT  = 64;
	localparam int PRIO_LEVELS = 256;

	localparam int TID_W  = 6;
	localparam int PRIO_W = 8;
	localparam int CNT_W  = $clog2(WAIT_DEPTH + 1);

	localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(PRIO_LEVELS - 1);

	typedef enum logic [1:0] {
		ACT_LOCK   = 2'd0,
		ACT_TRY    = 2'd1,
		ACT_UNLOCK = 2'd2,
		ACT_NONE   = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		ST_ACQUIRED  = 3'd0,
		ST_QUEUED    = 3'd1,
		ST_BUSY      = 3'd2,
		ST_RELEASED  = 3'd3,
		ST_HANDOVER  = 3'd4,
		ST_NOT_OWNER = 3'd5,
		ST_NOT_LOCK  = 3'd6,
		ST_FULL      = 3'd7
	} stat_t;

	typedef enum logic [0:0] {
		FSM_IDLE = 1'b0,
		FSM_EXEC = 1'b1
	} fsm_t;

	typedef struct packed {
		logic capture;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic op_valid;
	} sts_t;

	function automatic logic [PRIO_W-1:0] clamp_prio(input logic [PRIO_W-1:0] p);
		return (p > PRIO_MAX) ? PRIO_MAX : p;
	endfunction

	function automatic logic [TID_W-1:0] wrap_tid(input logic [TID_W-1:0] t);
		return TID_W'(t % TASK_COUNT);
	endfunction

endpackage

// ===== hdl/pim_ctrl.sv =====
// ----------------------------------------------------------------------------
// pim_ctrl: request sequencer
// Takes a request when idle, runs the execute state and then strobes done unless the action code is unused.
// ----------------------------------------------------------------------------
module pim_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  pim_pkg::sts_t sts,
	output pim_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done
);
	import pim_pkg::*;

	fsm_t state_q, state_d;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.exec && sts.op_valid;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = FSM_IDLE;
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	assign busy = (state_q != FSM_IDLE);
	assign done = done_q;

endmodule

// ===== hdl/pim_dpath.sv =====
// ----------------------------------------------------------------------------
// pim_dpath: owner registers and sorted wait queue
// Latches a request, applies it in the execute step and registers the result.
// ----------------------------------------------------------------------------
module pim_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pim_pkg::cmd_t              cmd,
	input  logic [1:0]                 action,
	input  logic [pim_pkg::TID_W-1:0]  task_id,
	input  logic [pim_pkg::PRIO_W-1:0] req_priority,
	input  logic [pim_pkg::PRIO_W-1:0] base_priority,
	output pim_pkg::sts_t              sts,
	output logic [2:0]                 status,
	output logic                       prio_valid,
	output logic [pim_pkg::TID_W-1:0]  prio_task,
	output logic [pim_pkg::PRIO_W-1:0] prio_value,
	output logic                       wake_valid,
	output logic [pim_pkg::TID_W-1:0]  wake_task
);
	import pim_pkg::*;

	// latched request
	act_t              act_q;
	logic [TID_W-1:0]  tid_q;
	logic [PRIO_W-1:0] rprio_q, bprio_q;

	// mutex state
	logic              held_q;
	logic [TID_W-1:0]  owner_id_q;
	logic [PRIO_W-1:0] owner_prio_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TID_W-1:0]  wid_q [WAIT_DEPTH];
	logic [PRIO_W-1:0] wpr_q [WAIT_DEPTH];

	// result registers
	stat_t             status_q;
	logic              pv_q, wv_q;
	logic [TID_W-1:0]  pt_q, wt_q;
	logic [PRIO_W-1:0] pval_q;

	logic [WAIT_DEPTH-1:0] keep;
	logic do_grab, do_insert, do_boost, do_pop, do_free;
	stat_t             stat_d;
	logic              pv_d, wv_d;
	logic [TID_W-1:0]  pt_d, wt_d;
	logic [PRIO_W-1:0] pval_d;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q   <= act_t'(action);
			tid_q   <= wrap_tid(task_id);
			rprio_q <= clamp_prio(req_priority);
			bprio_q <= clamp_prio(base_priority);
		end
	end

	// entries that stay ahead of a new waiter: occupied and not less urgent
	for (genvar i = 0; i < WAIT_DEPTH; i++) begin : g_cmp
		assign keep[i] = (CNT_W'(i) < cnt_q) && (wpr_q[i] <= rprio_q);
	end

	always_comb begin
		do_grab   = 1'b0;
		do_insert = 1'b0;
		do_boost  = 1'b0;
		do_pop    = 1'b0;
		do_free   = 1'b0;
		stat_d    = ST_ACQUIRED;
		pv_d      = 1'b0;
		pt_d      = '0;
		pval_d    = '0;
		wv_d      = 1'b0;
		wt_d      = '0;
		case (act_q)
			ACT_LOCK, ACT_TRY: begin
				if (!held_q) begin
					do_grab = 1'b1;
				end else if (act_q == ACT_TRY) begin
					stat_d = ST_BUSY;
				end else if (cnt_q == CNT_W'(WAIT_DEPTH)) begin
					stat_d = ST_FULL;
				end else begin
					do_insert = 1'b1;
					stat_d    = ST_QUEUED;
					if (rprio_q < owner_prio_q) begin
						do_boost = 1'b1;
						pv_d     = 1'b1;
						pt_d     = owner_id_q;
						pval_d   = rprio_q;
					end
				end
			end
			ACT_UNLOCK: begin
				if (!held_q) begin
					stat_d = ST_NOT_LOCK;
				end else if (tid_q != owner_id_q) begin
					stat_d = ST_NOT_OWNER;
				end else begin
					pv_d   = 1'b1;
					pt_d   = owner_id_q;
					pval_d = bprio_q;
					if (cnt_q == '0) begin
						do_free = 1'b1;
						stat_d  = ST_RELEASED;
					end else begin
						do_pop = 1'b1;
						wv_d   = 1'b1;
						wt_d   = wid_q[0];
						stat_d = ST_HANDOVER;
					end
				end
			end
			default: stat_d = ST_ACQUIRED;
		endcase
		sts.op_valid = (act_q != ACT_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= 1'b0;
			owner_id_q   <= '0;
			owner_prio_q <= '0;
			cnt_q        <= '0;
		end else if (cmd.exec) begin
			if (do_grab) begin
				held_q       <= 1'b1;
				owner_id_q   <= tid_q;
				owner_prio_q <= rprio_q;
			end
			if (do_boost) begin
				owner_prio_q <= rprio_q;
			end
			if (do_insert) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (do_free) begin
				held_q       <= 1'b0;
				owner_id_q   <= '0;
				owner_prio_q <= '0;
			end
			if (do_pop) begin
				owner_id_q   <= wid_q[0];
				owner_prio_q <= wpr_q[0];
				cnt_q        <= cnt_q - CNT_W'(1);
			end
		end
	end

	// queue cells: hold ahead of the slot, load the new waiter into it,
	// shift up behind it; on hand-over shift everything down by one
	for (genvar i = 0; i < WAIT_DEPTH; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (cmd.exec && do_insert && !keep[i]) begin
				if (i == 0 || keep[(i == 0) ? 0 : i-1]) begin
					wid_q[i] <= tid_q;
					wpr_q[i] <= rprio_q;
				end else begin
					wid_q[i] <= wid_q[(i == 0) ? 0 : i-1];
					wpr_q[i] <= wpr_q[(i == 0) ? 0 : i-1];
				end
			end else if (cmd.exec && do_pop && (i < WAIT_DEPTH-1)) begin
				wid_q[i] <= wid_q[(i < WAIT_DEPTH-1) ? i+1 : i];
				wpr_q[i] <= wpr_q[(i < WAIT_DEPTH-1) ? i+1 : i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= stat_d;
			pv_q     <= pv_d;
			pt_q     <= pt_d;
			pval_q   <= pval_d;
			wv_q     <= wv_d;
			wt_q     <= wt_d;
		end
	end

	assign status     = status_q;
	assign prio_valid = pv_q;
	assign prio_task  = pt_q;
	assign prio_value = pval_q;
	assign wake_valid = wv_q;
	assign wake_task  = wt_q;

endmodule

// ===== hdl/priority_inheritance_mutex.sv =====
// ----------------------------------------------------------------------------
// priority_inheritance_mutex: mutex with sorted wait queue and inheritance
// Lock, try-lock and unlock requests from tasks; reports grant, queueing,
// owner boost or restore, and hand-over wake-up of the next waiter.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive action, task_id, req_priority and base_priority
//   and raise start; the request transfers on the clock edge where start is
//   high and busy is low. busy then stays high during the execute state.
//   Result channel: once the execute state ends, done pulses for exactly one
//   cycle, with status, prio_* and wake_* valid in that cycle.
//   The receiver cannot stall; it must take each result as it appears.
//   An unused action code (3) is consumed but produces no result.
//   A new request is taken only while busy is low, so not during the
//   execute step, in which the wait queue, a row of shifting cells that
//   compare the new priority in parallel, inserts or pops the waiter.
//   Reset (arst_n low) frees the mutex and empties the queue at once; the
//   queue cells themselves are not cleared and are only read below the
//   waiter count.
// ----------------------------------------------------------------------------
module priority_inheritance_mutex (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 action,
	input  logic [pim_pkg::TID_W-1:0]  task_id,
	input  logic [pim_pkg::PRIO_W-1:0] req_priority,
	input  logic [pim_pkg::PRIO_W-1:0] base_priority,
	output logic                       done,
	output logic [2:0]                 status,
	output logic                       prio_valid,
	output logic [pim_pkg::TID_W-1:0]  prio_task,
	output logic [pim_pkg::PRIO_W-1:0] prio_value,
	output logic                       wake_valid,
	output logic [pim_pkg::TID_W-1:0]  wake_task
);
	import pim_pkg::*;

	// commands from the sequencer, status back from the datapath
	cmd_t cmd;
	sts_t sts;

	// sequencer: accept, execute, strobe
	pim_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// datapath: owner state, wait queue and result registers
	pim_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.action        (action),
		.task_id       (task_id),
		.req_priority  (req_priority),
		.base_priority (base_priority),
		.sts           (sts),
		.status        (status),
		.prio_valid    (prio_valid),
		.prio_task     (prio_task),
		.prio_value    (prio_value),
		.wake_valid    (wake_valid),
		.wake_task     (wake_task)
	);

endmodule
